// File: rtl/qgi_pkg.sv
// Shared types, widths and constants of the quaternion gyro integrator.
package qgi_pkg;

  // Width of one quaternion component, one gyro rate and the time step.
  localparam int Q_W = 16;
  // Q24 component after the update, with headroom for the increment.
  localparam int C_W = 30;
  // Exact derivative sum of three 16 by 16 products.
  localparam int D_W = 34;
  // Width of the step_us * STEP_K product and of the step factor.
  localparam int FP_W = 42;
  localparam int F_W = 26;
  // Width of the derivative times step factor product.
  localparam int P_W = 60;
  // Width of the sum of squares; it must be even.
  localparam int SS_W = 58;
  // Width of the integer square root.
  localparam int R_W = SS_W / 2;
  // Partial remainder of the square root recurrence.
  localparam int REM_W = R_W + 3;
  // Quotient bits of each normalizing division.
  localparam int QB = 15;
  // Width of the dividend and the division remainder.
  localparam int N_W = 44;

  // 0.5 * 1e-6 s * (pi/180) / 16 in Q56.
  localparam logic [F_W-1:0] STEP_K = F_W'(39301321);
  // Squared Q24 norm at or below which the result is degenerate.
  localparam logic [SS_W-1:0] NORM_MIN_SQ = SS_W'(28147);

  typedef enum logic [1:0] {
    CODE_OK         = 2'd0,
    CODE_BAD_STEP   = 2'd1,
    CODE_NO_SAMPLE  = 2'd2,
    CODE_DEGENERATE = 2'd3
  } qgi_code_e;

  typedef logic signed [C_W-1:0] qgi_comp_t;

  typedef struct packed {
    logic                  sample_present;
    logic signed [Q_W-1:0] q_w_in;
    logic signed [Q_W-1:0] q_x_in;
    logic signed [Q_W-1:0] q_y_in;
    logic signed [Q_W-1:0] q_z_in;
    logic signed [Q_W-1:0] rate_x;
    logic signed [Q_W-1:0] rate_y;
    logic signed [Q_W-1:0] rate_z;
    logic [Q_W-1:0]        step_us;
  } qgi_in_t;

  typedef struct packed {
    logic signed [Q_W-1:0] q_w_out;
    logic signed [Q_W-1:0] q_x_out;
    logic signed [Q_W-1:0] q_y_out;
    logic signed [Q_W-1:0] q_z_out;
    logic [1:0]            result_code;
  } qgi_out_t;

  // Status and updated components that ride along with the norm.
  typedef struct packed {
    qgi_code_e       code;
    qgi_comp_t [3:0] c;
  } qgi_side_t;

endpackage

// File: rtl/quaternion_gyro_integrator_top.sv
// Top level of the quaternion gyro integrator pipeline.
//
// This block advances an attitude quaternion by one first-order step of the
// gyro rates and renormalizes it, one input word per sample and exactly one
// result word per input word, in order. It is a fully pipelined datapath of
// 52 register stages: six for the products, step factor, update and sum of
// squares, 29 for the square root (one root bit per stage), one to form the
// dividends and 15 for the four parallel divisions (one quotient bit per
// stage), plus the output register. A new word can enter in every cycle in
// which the pipeline advances. The whole pipeline advances together; it
// holds only while the output register carries a word that the sink has
// not taken, so in_ready_o follows out_ready_i in that case.
// Words with a zero step, an absent sample or a zero quaternion, and words
// whose updated norm is degenerate, still flow through the pipeline and come
// out with their status code and zero components.
module quaternion_gyro_integrator_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qgi_pkg::qgi_in_t   in_word_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output qgi_pkg::qgi_out_t  out_word_o,
  output logic               out_valid_o,
  input  logic               out_ready_i
);
  import qgi_pkg::*;

  // One enable moves every stage at once.
  logic en;
  logic out_vld_q;
  qgi_out_t out_word_q;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // Stage 1: the twelve component-by-rate products and the raw step product.
  logic                  s1_vld_q;
  logic signed [31:0]    s1_pr_q [12];
  logic signed [31:0]    s1_pr_d [12];
  logic [FP_W-1:0]       s1_fp_q;
  logic signed [Q_W-1:0] s1_qc_q [4];
  qgi_code_e             s1_code_q;
  qgi_code_e             s1_code_d;

  // The step check comes first, then the sample and zero quaternion check.
  always_comb begin
    if (in_word_i.step_us == '0) begin
      s1_code_d = CODE_BAD_STEP;
    end else if (!in_word_i.sample_present ||
                 (in_word_i.q_w_in == '0 && in_word_i.q_x_in == '0 &&
                  in_word_i.q_y_in == '0 && in_word_i.q_z_in == '0)) begin
      s1_code_d = CODE_NO_SAMPLE;
    end else begin
      s1_code_d = CODE_OK;
    end
    s1_pr_d[0]  = in_word_i.q_x_in * in_word_i.rate_x;
    s1_pr_d[1]  = in_word_i.q_y_in * in_word_i.rate_y;
    s1_pr_d[2]  = in_word_i.q_z_in * in_word_i.rate_z;
    s1_pr_d[3]  = in_word_i.q_w_in * in_word_i.rate_x;
    s1_pr_d[4]  = in_word_i.q_y_in * in_word_i.rate_z;
    s1_pr_d[5]  = in_word_i.q_z_in * in_word_i.rate_y;
    s1_pr_d[6]  = in_word_i.q_w_in * in_word_i.rate_y;
    s1_pr_d[7]  = in_word_i.q_x_in * in_word_i.rate_z;
    s1_pr_d[8]  = in_word_i.q_z_in * in_word_i.rate_x;
    s1_pr_d[9]  = in_word_i.q_w_in * in_word_i.rate_z;
    s1_pr_d[10] = in_word_i.q_x_in * in_word_i.rate_y;
    s1_pr_d[11] = in_word_i.q_y_in * in_word_i.rate_x;
  end

  // Stage 2: the four derivative sums and the rounded step factor in Q40.
  logic                  s2_vld_q;
  logic signed [D_W-1:0] s2_d_q [4];
  logic [F_W-1:0]        s2_f_q;
  logic signed [Q_W-1:0] s2_qc_q [4];
  qgi_code_e             s2_code_q;

  // Stage 3: each derivative times the step factor.
  logic                  s3_vld_q;
  logic signed [P_W-1:0] s3_p_q [4];
  logic signed [Q_W-1:0] s3_qc_q [4];
  qgi_code_e             s3_code_q;

  // Stage 4: rounded increment added to the component in Q24.
  logic                  s4_vld_q;
  qgi_comp_t             s4_c_q [4];
  qgi_comp_t             s4_c_d [4];
  qgi_code_e             s4_code_q;

  always_comb begin
    logic [P_W-1:0] mag;
    logic [P_W-1:0] rnd;
    mag = '0;
    rnd = '0;
    for (int i = 0; i < 4; i++) begin
      mag = s3_p_q[i][P_W-1] ? P_W'(-s3_p_q[i]) : P_W'(s3_p_q[i]);
      rnd = (mag + (P_W'(1) << 29)) >> 30;
      s4_c_d[i] = (C_W'(s3_qc_q[i]) <<< 10) +
                  (s3_p_q[i][P_W-1] ? -C_W'(rnd) : C_W'(rnd));
    end
  end

  // Stage 5: squares of the updated components.
  logic                  s5_vld_q;
  logic [SS_W-1:0]       s5_sq_q [4];
  logic [SS_W-1:0]       s5_sq_d [4];
  qgi_comp_t             s5_c_q [4];
  qgi_code_e             s5_code_q;

  always_comb begin
    logic signed [2*C_W-1:0] prod;
    prod = '0;
    for (int i = 0; i < 4; i++) begin
      prod       = s4_c_q[i] * s4_c_q[i];
      s5_sq_d[i] = prod[SS_W-1:0];
    end
  end

  // Stage 6: sum of squares and the degenerate norm check.
  logic                  s6_vld_q;
  logic [SS_W-1:0]       s6_ss_q;
  logic [SS_W-1:0]       s6_ss_d;
  qgi_side_t             s6_side_q;
  qgi_side_t             s6_side_d;

  always_comb begin
    s6_ss_d = s5_sq_q[0] + s5_sq_q[1] + s5_sq_q[2] + s5_sq_q[3];
    if (s5_code_q == CODE_OK && s6_ss_d <= NORM_MIN_SQ) begin
      s6_side_d.code = CODE_DEGENERATE;
    end else begin
      s6_side_d.code = s5_code_q;
    end
    for (int i = 0; i < 4; i++) begin
      s6_side_d.c[i] = s5_c_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pr_q    <= s1_pr_d;
      s1_fp_q    <= in_word_i.step_us * STEP_K;
      s1_qc_q[0] <= in_word_i.q_w_in;
      s1_qc_q[1] <= in_word_i.q_x_in;
      s1_qc_q[2] <= in_word_i.q_y_in;
      s1_qc_q[3] <= in_word_i.q_z_in;
      s1_code_q  <= s1_code_d;

      s2_d_q[0] <= D_W'(0) - s1_pr_q[0] - s1_pr_q[1] - s1_pr_q[2];
      s2_d_q[1] <= D_W'(s1_pr_q[3]) + s1_pr_q[4] - s1_pr_q[5];
      s2_d_q[2] <= D_W'(s1_pr_q[6]) - s1_pr_q[7] + s1_pr_q[8];
      s2_d_q[3] <= D_W'(s1_pr_q[9]) + s1_pr_q[10] - s1_pr_q[11];
      s2_f_q    <= F_W'((s1_fp_q + FP_W'(32768)) >> 16);
      s2_qc_q   <= s1_qc_q;
      s2_code_q <= s1_code_q;

      for (int i = 0; i < 4; i++) begin
        s3_p_q[i] <= s2_d_q[i] * $signed({1'b0, s2_f_q});
      end
      s3_qc_q   <= s2_qc_q;
      s3_code_q <= s2_code_q;

      s4_c_q    <= s4_c_d;
      s4_code_q <= s3_code_q;

      s5_sq_q   <= s5_sq_d;
      s5_c_q    <= s4_c_q;
      s5_code_q <= s4_code_q;

      s6_ss_q   <= s6_ss_d;
      s6_side_q <= s6_side_d;
    end
  end

  // Square root of the sum of squares, with the status and components riding along.
  logic             sq_vld;
  logic [R_W-1:0]   sq_root;
  qgi_side_t        sq_side;

  qgi_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s6_vld_q),
    .rad_i  (s6_ss_q),
    .side_i (s6_side_q),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // Division of each component by the norm, rounded and signed.
  logic     dv_vld;
  qgi_out_t dv_word;

  qgi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sq_vld),
    .norm_i (sq_root),
    .side_i (sq_side),
    .vld_o  (dv_vld),
    .word_o (dv_word)
  );

  // Output register: holds a word until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_word_q <= dv_word;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_word_q;

endmodule

// File: rtl/qgi_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
module qgi_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  logic [qgi_pkg::SS_W-1:0]   rad_i,
  input  qgi_pkg::qgi_side_t         side_i,
  output logic                       vld_o,
  output logic [qgi_pkg::R_W-1:0]    root_o,
  output qgi_pkg::qgi_side_t         side_o
);
  import qgi_pkg::*;

  logic              st_vld  [R_W+1];
  logic [SS_W-1:0]   st_x    [R_W+1];
  logic [REM_W-1:0]  st_rem  [R_W+1];
  logic [R_W-1:0]    st_root [R_W+1];
  qgi_side_t         st_side [R_W+1];

  assign st_vld[0]  = vld_i;
  assign st_x[0]    = rad_i;
  assign st_rem[0]  = '0;
  assign st_root[0] = '0;
  assign st_side[0] = side_i;

  for (genvar k = 0; k < R_W; k++) begin : g_stage
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;
    logic             vld_q;
    logic [SS_W-1:0]  x_q;
    logic [REM_W-1:0] rem_q;
    logic [R_W-1:0]   root_q;
    qgi_side_t        side_q;

    // Bring down the next two radicand bits and try the next root bit.
    always_comb begin
      rem_sh = {st_rem[k][REM_W-3:0], st_x[k][SS_W-1 -: 2]};
      trial  = REM_W'({st_root[k], 2'b01});
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= st_vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q    <= st_x[k] << 2;
        rem_q  <= ge ? (rem_sh - trial) : rem_sh;
        root_q <= {st_root[k][R_W-2:0], ge};
        side_q <= st_side[k];
      end
    end

    assign st_vld[k+1]  = vld_q;
    assign st_x[k+1]    = x_q;
    assign st_rem[k+1]  = rem_q;
    assign st_root[k+1] = root_q;
    assign st_side[k+1] = side_q;
  end

  assign vld_o  = st_vld[R_W];
  assign root_o = st_root[R_W];
  assign side_o = st_side[R_W];

endmodule

// File: rtl/qgi_div.sv
// Four-lane pipelined rounding division of the components by the norm.
module qgi_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     vld_i,
  input  logic [qgi_pkg::R_W-1:0]  norm_i,
  input  qgi_pkg::qgi_side_t       side_i,
  output logic                     vld_o,
  output qgi_pkg::qgi_out_t        word_o
);
  import qgi_pkg::*;

  logic                  pre_vld_q;
  logic [R_W-1:0]        pre_n_q;
  qgi_code_e             pre_code_q;
  logic [3:0]            pre_neg_q;
  logic [3:0][N_W-1:0]   pre_num_q;
  logic [3:0]            pre_neg_d;
  logic [3:0][N_W-1:0]   pre_num_d;

  // Dividend is |c| * 2^14 plus half the norm, so truncation rounds half up.
  always_comb begin
    logic [C_W-1:0] mag;
    mag = '0;
    for (int i = 0; i < 4; i++) begin
      pre_neg_d[i] = side_i.c[i][C_W-1];
      mag          = pre_neg_d[i] ? C_W'(-side_i.c[i]) : C_W'(side_i.c[i]);
      pre_num_d[i] = (N_W'(mag) << 14) + N_W'(norm_i >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= 1'b0;
    end else if (en_i) begin
      pre_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pre_n_q    <= norm_i;
      pre_code_q <= side_i.code;
      pre_neg_q  <= pre_neg_d;
      pre_num_q  <= pre_num_d;
    end
  end

  logic                 dv_vld  [QB+1];
  logic [R_W-1:0]       dv_n    [QB+1];
  qgi_code_e            dv_code [QB+1];
  logic [3:0]           dv_neg  [QB+1];
  logic [3:0][N_W-1:0]  dv_rem  [QB+1];
  logic [3:0][QB-1:0]   dv_quo  [QB+1];

  assign dv_vld[0]  = pre_vld_q;
  assign dv_n[0]    = pre_n_q;
  assign dv_code[0] = pre_code_q;
  assign dv_neg[0]  = pre_neg_q;
  assign dv_rem[0]  = pre_num_q;
  assign dv_quo[0]  = '0;

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [N_W-1:0]       dsh;
    logic [3:0][N_W-1:0]  rem_d;
    logic [3:0][QB-1:0]   quo_d;
    logic                 vld_q;
    logic [R_W-1:0]       n_q;
    qgi_code_e            code_q;
    logic [3:0]           neg_q;
    logic [3:0][N_W-1:0]  rem_q;
    logic [3:0][QB-1:0]   quo_q;

    // Restoring step for quotient bit QB-1-s in each lane.
    always_comb begin
      dsh = N_W'(dv_n[s]) << (QB - 1 - s);
      for (int i = 0; i < 4; i++) begin
        if (dv_rem[s][i] >= dsh) begin
          rem_d[i] = dv_rem[s][i] - dsh;
          quo_d[i] = {dv_quo[s][i][QB-2:0], 1'b1};
        end else begin
          rem_d[i] = dv_rem[s][i];
          quo_d[i] = {dv_quo[s][i][QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= dv_vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q    <= dv_n[s];
        code_q <= dv_code[s];
        neg_q  <= dv_neg[s];
        rem_q  <= rem_d;
        quo_q  <= quo_d;
      end
    end

    assign dv_vld[s+1]  = vld_q;
    assign dv_n[s+1]    = n_q;
    assign dv_code[s+1] = code_q;
    assign dv_neg[s+1]  = neg_q;
    assign dv_rem[s+1]  = rem_q;
    assign dv_quo[s+1]  = quo_q;
  end

  // The quotient never exceeds 2^15 - 1, so sign application cannot overflow.
  logic signed [3:0][Q_W-1:0] res;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (dv_code[QB] != CODE_OK) begin
        res[i] = '0;
      end else if (dv_neg[QB][i]) begin
        res[i] = -Q_W'(dv_quo[QB][i]);
      end else begin
        res[i] = Q_W'(dv_quo[QB][i]);
      end
    end
    word_o.q_w_out     = res[0];
    word_o.q_x_out     = res[1];
    word_o.q_y_out     = res[2];
    word_o.q_z_out     = res[3];
    word_o.result_code = dv_code[QB];
  end

  assign vld_o = dv_vld[QB];

endmodule
